@@ design/pdmq_pkg.sv @@
// Package for the priority drop message queue.
// Holds sizes, payload and command types, codes and slot index helpers.
// No dependencies.
package pdmq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MESSAGE_BYTES = 64;
	localparam int HIGH_PRIORITY = 2;

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int BYTE_W = $clog2(MESSAGE_BYTES);
	localparam int BIDX_W = $clog2(MESSAGE_BYTES + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH * MESSAGE_BYTES);

	typedef enum logic [2:0] {
		OP_ENQ   = 3'd0,
		OP_DEQ   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_SWEEP = 3'd3,
		OP_TICK  = 3'd4,
		OP_CLEAR = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_BYTE   = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_REJECT = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_SWEEP  = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE, S_PUSH, S_LOWSCAN, S_CMP_META, S_CMP_BYTE, S_FULLCHK, S_COPY,
		S_RETIRE, S_FIND, S_DELIV, S_SWEEP, S_OLD_INIT, S_OLD, S_EMIT, S_BRD, S_BLD
	} state_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] byte_value;
		logic       last_byte;
		logic [7:0] priority_req;
		logic [6:0] read_limit;
	} in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  data_byte;
		logic        last;
		logic [5:0]  copy_length;
		logic [4:0]  removed_count;
		logic [4:0]  occupied;
		logic [31:0] oldest_time;
	} out_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] byte_value;
		logic       last_byte;
		logic       high;
		logic [6:0] limit;
	} cmd_t;

	function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : s - 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
			input logic [BIDX_W-1:0] b);
		return ADDR_W'(s) * ADDR_W'(MESSAGE_BYTES) + ADDR_W'(b);
	endfunction

endpackage

@@ design/pdmq_front.sv @@
// Front end of the message queue: takes input items, classifies them into commands.
// Commands wait in a two-entry queue for the back end. Depends on pdmq_pkg.
module pdmq_front import pdmq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);

	cmd_t       fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	cmd_t       cmd_d;

	assign in_ready = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = fifo_q[rp_q];
	assign pop = cmd_valid && cmd_pop;

	always_comb begin
		cmd_d.op = op_t'(in_data.operation);
		cmd_d.byte_value = in_data.byte_value;
		cmd_d.last_byte = in_data.last_byte;
		cmd_d.high = (in_data.priority_req >= 8'(HIGH_PRIORITY));
		cmd_d.limit = (in_data.read_limit == 7'd0) ? 7'd1 : in_data.read_limit;
		push = in_valid && in_ready && (in_data.operation inside {[OP_ENQ:OP_CLEAR]});
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ design/pdmq_back.sv @@
// Back end of the message queue: a sequencer that executes one command at a time.
// Holds the slot and staging memories, slot metadata and the output register.
// Depends on pdmq_pkg.
module pdmq_back import pdmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	logic [7:0]  slot_mem [QUEUE_DEPTH * MESSAGE_BYTES];
	logic [7:0]  stg_mem [MESSAGE_BYTES];
	logic [5:0]  len_q [QUEUE_DEPTH];
	logic        high_q [QUEUE_DEPTH];
	logic [31:0] time_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;

	state_t      state_q, state_d;
	cmd_t        cmd_q;
	logic [BYTE_W-1:0] scnt_q;
	logic        ovf_q;
	logic [SLOT_W-1:0] wr_q, rd_q, tgt_q;
	logic [CNT_W-1:0]  cnt_q, k_q, removed_q;
	logic [BIDX_W-1:0] b_q;
	logic [31:0] now_q, timeout_q, oldest_q;
	logic [5:0]  clen_q;
	status_t     status_q;
	logic [7:0]  slot_rdata_q, stg_rdata_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [SLOT_W-1:0] scan_slot, src_slot, meta_ra;
	logic [CNT_W-1:0]  k_next;
	logic        k_end, m_valid, m_high, age_old, out_free, stg_room, enq_reject;
	logic [5:0]  m_len, clen_d;
	logic [31:0] m_time;
	logic [ADDR_W-1:0] slot_raddr, slot_waddr;
	logic        slot_we;
	logic [7:0]  slot_wdata;
	logic        stg_we;
	logic        out_load;
	out_t        out_d;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		k_next = k_q + 1'b1;
		scan_slot = slot_at(rd_q, k_q);
		src_slot = slot_at(rd_q, k_next);
		k_end = (k_q >= cnt_q);
		case (state_q)
			S_RETIRE:   meta_ra = rd_q;
			S_DELIV:    meta_ra = tgt_q;
			S_CMP_META: meta_ra = src_slot;
			default:    meta_ra = scan_slot;
		endcase
		m_valid = valid_q[meta_ra];
		m_high = high_q[meta_ra];
		m_len = len_q[meta_ra];
		m_time = time_q[meta_ra];
		age_old = ((now_q - m_time) > timeout_q);
		out_free = !out_valid_q || out_ready;
		stg_room = (scnt_q < BYTE_W'(MESSAGE_BYTES - 1));
		enq_reject = ovf_q || !stg_room;
		clen_d = (7'(m_len) < cmd_q.limit) ? m_len : 6'(cmd_q.limit - 7'd1);
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		out_load = 1'b0;
		out_d = '0;
		out_d.occupied = 5'(cnt_q);
		out_d.oldest_time = oldest_q;
		stg_we = 1'b0;
		slot_we = 1'b0;
		slot_waddr = slot_addr(scan_slot, b_q - 1'b1);
		slot_wdata = slot_rdata_q;
		slot_raddr = slot_addr(tgt_q, b_q);
		case (state_q)
			S_IDLE: begin
				cmd_pop = 1'b1;
				if (cmd_valid) begin
					case (cmd.op)
						OP_ENQ: begin
							stg_we = stg_room;
							if (cmd.last_byte) begin
								state_d = enq_reject ? S_OLD_INIT : S_PUSH;
							end
						end
						OP_DEQ:   state_d = S_RETIRE;
						OP_PEEK:  state_d = S_FIND;
						OP_SWEEP: state_d = S_SWEEP;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_PUSH: begin
				if (cnt_q == CNT_W'(QUEUE_DEPTH) && cmd_q.high) begin
					state_d = S_LOWSCAN;
				end else begin
					state_d = S_FULLCHK;
				end
			end
			S_LOWSCAN: begin
				if (k_end) begin
					state_d = S_FULLCHK;
				end else if (m_valid && !m_high) begin
					state_d = S_CMP_META;
				end
			end
			S_CMP_META: state_d = (k_next >= cnt_q) ? S_FULLCHK : S_CMP_BYTE;
			S_CMP_BYTE: begin
				slot_raddr = slot_addr(src_slot, b_q);
				slot_we = (b_q != '0);
				if (b_q == BIDX_W'(MESSAGE_BYTES)) begin
					state_d = S_CMP_META;
				end
			end
			S_FULLCHK: state_d = S_COPY;
			S_COPY: begin
				slot_we = (b_q != '0);
				slot_waddr = slot_addr(wr_q, b_q - 1'b1);
				slot_wdata = stg_rdata_q;
				if (b_q == BIDX_W'(scnt_q)) begin
					state_d = S_OLD_INIT;
				end
			end
			S_RETIRE: begin
				if (!(cnt_q != '0 && !m_valid)) begin
					if (cmd_q.op == OP_SWEEP || cnt_q == '0) begin
						state_d = S_OLD_INIT;
					end else begin
						state_d = S_DELIV;
					end
				end
			end
			S_FIND: begin
				if (k_end) begin
					state_d = S_OLD_INIT;
				end else if (m_valid) begin
					state_d = S_DELIV;
				end
			end
			S_DELIV: state_d = S_OLD_INIT;
			S_SWEEP: begin
				if (k_end) begin
					state_d = S_RETIRE;
				end
			end
			S_OLD_INIT: state_d = S_OLD;
			S_OLD: begin
				if (k_end || m_valid) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (status_q == ST_BYTE && clen_q != '0) begin
					state_d = S_BRD;
				end else if (out_free) begin
					out_load = 1'b1;
					out_d.status = status_q;
					out_d.last = 1'b1;
					out_d.removed_count = 5'(removed_q);
					state_d = S_IDLE;
				end
			end
			S_BRD: state_d = S_BLD;
			S_BLD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d.status = ST_BYTE;
					out_d.data_byte = slot_rdata_q;
					out_d.last = (BIDX_W'(b_q + 1'b1) == BIDX_W'(clen_q));
					out_d.copy_length = clen_q;
					state_d = out_d.last ? S_IDLE : S_BRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_rdata_q <= slot_mem[slot_raddr];
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	always_ff @(posedge clk) begin
		stg_rdata_q <= stg_mem[b_q[BYTE_W-1:0]];
		if (stg_we) begin
			stg_mem[scnt_q] <= cmd.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			scnt_q <= '0;
			ovf_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			now_q <= '0;
			timeout_q <= '1;
			k_q <= '0;
			b_q <= '0;
			removed_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				timeout_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					b_q <= '0;
					removed_q <= '0;
					if (cmd_valid) begin
						case (cmd.op)
							OP_ENQ: begin
								if (cmd.last_byte && enq_reject) begin
									scnt_q <= '0;
									ovf_q <= 1'b0;
								end else if (stg_room) begin
									scnt_q <= scnt_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_TICK: now_q <= now_q + 32'd1;
							OP_CLEAR: begin
								valid_q <= '0;
								wr_q <= '0;
								rd_q <= '0;
								cnt_q <= '0;
								scnt_q <= '0;
								ovf_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_LOWSCAN: begin
					if (!k_end && !(m_valid && !m_high)) begin
						k_q <= k_next;
					end
				end
				S_CMP_META: begin
					b_q <= '0;
					if (k_next >= cnt_q) begin
						wr_q <= slot_dec(wr_q);
						cnt_q <= cnt_q - 1'b1;
					end else begin
						valid_q[scan_slot] <= m_valid;
					end
				end
				S_CMP_BYTE: begin
					if (b_q == BIDX_W'(MESSAGE_BYTES)) begin
						k_q <= k_next;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				S_FULLCHK: begin
					b_q <= '0;
					if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
						rd_q <= slot_inc(rd_q);
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_COPY: begin
					if (b_q == BIDX_W'(scnt_q)) begin
						valid_q[wr_q] <= 1'b1;
						wr_q <= slot_inc(wr_q);
						cnt_q <= cnt_q + 1'b1;
						scnt_q <= '0;
						ovf_q <= 1'b0;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				S_RETIRE: begin
					if (cnt_q != '0 && !m_valid) begin
						rd_q <= slot_inc(rd_q);
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIND: begin
					if (!k_end && !m_valid) begin
						k_q <= k_next;
					end
				end
				S_DELIV: begin
					if (cmd_q.op == OP_DEQ) begin
						valid_q[tgt_q] <= 1'b0;
						rd_q <= slot_inc(rd_q);
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SWEEP: begin
					if (!k_end) begin
						if (m_valid && age_old) begin
							valid_q[scan_slot] <= 1'b0;
							removed_q <= removed_q + 1'b1;
						end
						k_q <= k_next;
					end
				end
				S_OLD_INIT: begin
					k_q <= '0;
					b_q <= '0;
				end
				S_OLD: begin
					if (!k_end && !m_valid) begin
						k_q <= k_next;
					end
				end
				S_BLD: begin
					if (out_free) begin
						b_q <= b_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
					clen_q <= '0;
					status_q <= enq_reject ? ST_REJECT : ST_ACCEPT;
				end
			end
			S_CMP_META: begin
				if (k_next < cnt_q) begin
					len_q[scan_slot] <= m_len;
					high_q[scan_slot] <= m_high;
					time_q[scan_slot] <= m_time;
				end
			end
			S_COPY: begin
				if (b_q == BIDX_W'(scnt_q)) begin
					len_q[wr_q] <= 6'(scnt_q);
					high_q[wr_q] <= cmd_q.high;
					time_q[wr_q] <= now_q;
				end
			end
			S_RETIRE: begin
				if (!(cnt_q != '0 && !m_valid)) begin
					tgt_q <= rd_q;
					if (cmd_q.op == OP_SWEEP) begin
						status_q <= ST_SWEEP;
					end else if (cnt_q == '0) begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_FIND: begin
				if (k_end) begin
					status_q <= ST_EMPTY;
				end else if (m_valid) begin
					tgt_q <= scan_slot;
				end
			end
			S_DELIV: begin
				clen_q <= clen_d;
				status_q <= ST_BYTE;
			end
			S_OLD: begin
				if (k_end) begin
					oldest_q <= '0;
				end else if (m_valid) begin
					oldest_q <= m_time;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("slot count above queue depth");

	a_stg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= BYTE_W'(MESSAGE_BYTES - 1))
		else $error("staging count above message limit");

	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT || $past(state_q) == S_BLD))
		else $error("result item loaded outside an emit state");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cmd_valid && cmd.op == OP_CLEAR) |=>
		(cnt_q == '0 && valid_q == '0 && scnt_q == '0))
		else $error("clear left entries behind");
`endif

endmodule

@@ design/priority_drop_message_queue_top.sv @@
// Top level of the priority drop message queue.
// Instantiates pdmq_front and pdmq_back; depends on pdmq_pkg.
//
// The queue keeps up to QUEUE_DEPTH messages of up to MESSAGE_BYTES-1 bytes and
// executes one command at a time, while the front buffers two more items. The
// final byte of an accepted enqueue copies the message from the staging buffer at
// one byte per cycle. When a high priority message meets a full ring, each slot
// moved toward the evicted one is copied byte by byte through the slot memory.
// Dequeue and peek deliver each byte through a read state and a load state that
// waits while the output is full, after a scan of one slot per cycle; sweeps and
// the search for the oldest timestamp also walk one slot per cycle.
// The expiry timeout register accepts writes on every cycle.
module priority_drop_message_queue_top import pdmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	pdmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	pdmq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
